@@ src/spf_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the servo packet framer.
// Depends on nothing; imported by every module of the framer.
package spf_pkg;

    // Packet prefix marker and CRC polynomial
    localparam logic [7:0]  PREFIX_MARK = 8'hFD;
    localparam logic [15:0] CRC_POLY    = 16'h8005;

    // Configuration register indexes and reset values
    localparam int          CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;
    localparam logic [7:0]  HEADER_RESET   = 8'hFF;
    localparam logic [7:0]  RESERVED_RESET = 8'h00;

    // One command byte with its end-of-packet marker
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_spf_beat;

    // Framer phase: which byte of the packet goes out next
    typedef enum logic [6:0] {
        S_HDR0  = 7'b0000001,
        S_HDR1  = 7'b0000010,
        S_MARK  = 7'b0000100,
        S_RSVD  = 7'b0001000,
        S_BODY  = 7'b0010000,
        S_CRCLO = 7'b0100000,
        S_CRCHI = 7'b1000000
    } t_spf_state;

    // Fold one byte into the CRC, MSB first, no reflection
    function automatic logic [15:0] spf_crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/spf_in_reg.sv @@
// Input register stage of the servo packet framer: holds one accepted command beat.
// Depends on spf_pkg for the beat type.
module spf_in_reg
    import spf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_spf_beat i_beat,
    output logic      o_ready,
    output logic      o_valid,
    output t_spf_beat o_beat,
    input  logic      i_take
);

    logic      r_valid;
    t_spf_beat r_beat;

    // Accept when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

@@ src/spf_emit.sv @@
// Sequencer and output register: prefix, body, CRC one byte per cycle unless stalled.
// Depends on spf_pkg for the phase enum, beat type and CRC update.
module spf_emit
    import spf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_header,
    input  logic [7:0] i_reserved,
    input  logic       i_in_valid,
    input  t_spf_beat  i_in_beat,
    output logic       o_take,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    input  logic       i_out_ready
);

    t_spf_state  r_state, n_state;
    logic [15:0] r_crc, n_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        w_trailer;
    logic        w_fire;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_upd;
    logic [15:0] w_crc_next;

    // Trailer bytes need no input beat; everything else waits for one
    assign w_trailer  = (r_state == S_CRCLO) || (r_state == S_CRCHI);
    assign w_fire     = (w_trailer || i_in_valid) && (!r_out_valid || i_out_ready);
    assign o_take     = w_fire && (r_state == S_BODY);
    assign w_crc_next = spf_crc_add(r_crc, w_byte);

    // Select the byte for this phase and the following phase
    always_comb begin
        n_state = r_state;
        w_byte  = i_in_beat.data;
        w_last  = 1'b0;
        w_upd   = 1'b1;
        case (r_state)
            S_HDR0: begin
                w_byte  = i_header;
                n_state = S_HDR1;
            end
            S_HDR1: begin
                w_byte  = i_header;
                n_state = S_MARK;
            end
            S_MARK: begin
                w_byte  = PREFIX_MARK;
                n_state = S_RSVD;
            end
            S_RSVD: begin
                w_byte  = i_reserved;
                n_state = S_BODY;
            end
            S_BODY: begin
                w_byte  = i_in_beat.data;
                n_state = i_in_beat.last ? S_CRCLO : S_BODY;
            end
            S_CRCLO: begin
                w_byte  = r_crc[7:0];
                w_upd   = 1'b0;
                n_state = S_CRCHI;
            end
            S_CRCHI: begin
                w_byte  = r_crc[15:8];
                w_last  = 1'b1;
                w_upd   = 1'b0;
                n_state = S_HDR0;
            end
            default: begin
                w_upd   = 1'b0;
                n_state = S_HDR0;
            end
        endcase
        n_crc = r_crc;
        if (r_state == S_CRCHI) begin
            n_crc = 16'h0000;
        end else if (w_upd) begin
            n_crc = w_crc_next;
        end
    end

    // Advance phase and CRC on each emitted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR0;
            r_crc   <= 16'h0000;
        end else if (w_fire) begin
            r_state <= n_state;
            r_crc   <= n_crc;
        end
    end

    // Output register valid: set on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    // A waiting end-of-packet byte means the sequencer is back at packet start
    a_last_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_state == S_HDR0))
        else $error("end-of-packet byte pending outside packet start");

    // CRC is cleared whenever a new packet is about to begin
    a_crc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR0) |-> (r_crc == 16'h0000))
        else $error("CRC not cleared at packet start");

    // Trailer bytes never consume an input beat
    a_no_take_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_trailer |-> !o_take)
        else $error("input beat consumed during CRC trailer");

    // After the reserved byte the next phase is the body
    a_rsvd_to_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_state == S_RSVD)) |=> (r_state == S_BODY))
        else $error("prefix not followed by body phase");

endmodule

@@ src/servo_packet_framer_crc16.sv @@
// Servo packet framer, top level: configuration registers, input stage, framer.
// Depends on spf_pkg, spf_in_reg and spf_emit.
//
// Usage: command bytes enter on the body channel (i_body_valid / o_body_ready),
// with i_body_last on the final byte of a packet. Framed bytes leave on the
// out channel (o_out_valid / i_out_ready), o_out_last high on the CRC high byte.
// Each packet goes out as: header, header, 0xFD, reserved, body bytes, CRC low,
// CRC high. CRC-16 poly 0x8005, init 0, no reflection, over prefix and body.
// A body byte passes through the input register, then the output register;
// an opening beat waits behind its prefix. Throughput: one output byte per
// cycle while the receiver is ready and body bytes arrive, set by the single
// output register; with both, mid-packet a body byte is taken every cycle. A
// packet of N body bytes leaves as N+6 bytes; input stalls in prefix and trailer.
// Reset (synchronous, active low) clears both pipeline stages, returns the
// framer to packet start with CRC zero, header to 0xFF and reserved to 0x00.
// A receiver stall holds the output byte; back pressure reaches o_body_ready
// once the input register is full. Configuration writes take effect from the
// next packet prefix; write only while no packet is in flight.
module servo_packet_framer_crc16
    import spf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_body_valid,
    output logic                 o_body_ready,
    input  logic [7:0]           i_body_byte,
    input  logic                 i_body_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last
);

    logic [7:0] r_header;
    logic [7:0] r_reserved;
    t_spf_beat  w_in_beat;
    t_spf_beat  w_held_beat;
    logic       w_held_valid;
    logic       w_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= HEADER_RESET;
            r_reserved <= RESERVED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER:   r_header   <= i_cfg_data;
                CFG_RESERVED: r_reserved <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_in_beat.data = i_body_byte;
    assign w_in_beat.last = i_body_last;

    // Hold one input beat
    spf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_body_valid),
        .i_beat  (w_in_beat),
        .o_ready (o_body_ready),
        .o_valid (w_held_valid),
        .o_beat  (w_held_beat),
        .i_take  (w_take)
    );

    // Sequence prefix, body and CRC into the output register
    spf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_header    (r_header),
        .i_reserved  (r_reserved),
        .i_in_valid  (w_held_valid),
        .i_in_beat   (w_held_beat),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .i_out_ready (i_out_ready)
    );

endmodule
